// ===== sv/lwda_pkg.sv =====
`timescale 1ns / 1ps

package lwda_pkg;

    localparam int MAX_STEPS_DEF = 128;
    localparam int MAX_WALKS_DEF = 1024;

    localparam int WALKS_REG_W = 11;
    localparam int STEPS_REG_W = 7;
    localparam int POS_W       = 8;
    localparam int D2_W        = 14;
    localparam int STEPNUM_W   = 7;
    localparam int BLK_W       = 12;
    localparam int SUM_W       = 24;
    localparam int SQ_PROD_W   = 2 * SUM_W;
    localparam int DIST_W      = 36;
    localparam int SQTOT_W     = 60;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [BLK_W-1:0] BLK_MAX = '1;

    localparam logic [WALKS_REG_W-1:0] WALKS_RESET = WALKS_REG_W'(100);
    localparam logic [STEPS_REG_W-1:0] STEPS_RESET = STEPS_REG_W'(100);

    typedef enum logic [0:0] {
        OP_STEP = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [0:0] {
        REG_WALKS = 1'b0,
        REG_STEPS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic                 ovf;
        logic [SQTOT_W-1:0]   sq;
        logic [DIST_W-1:0]    dsum;
    } tot_t;

    localparam int TOT_W = $bits(tot_t);

    typedef struct packed {
        logic accept;
        logic finish;
        logic clear;
        logic sweep_rd;
    } lwda_cmd_t;

    typedef struct packed {
        logic out_free;
        logic block_end;
    } lwda_status_t;

endpackage

// ===== sv/lattice_walk_distance_accumulator.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake             | Payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | operation, direction, axis, read_index
// out      | out_valid / out_stall | squared_distance, step_number, walk_done,
//          |                       | block_done, blocks_finished, total_distance,
//          |                       | total_square, saturated
// cfg      | APB write/read        | walks_per_block (0x0), steps_per_walk (0x4)
//
// Each transaction reads the per-step sum or totals RAM when it is accepted,
// then does the write-back and result register load once the output is free.
// A step that ends a block is followed by a sweep through both RAMs
// (multiply and saturating add pipeline) with in_stall high.
// After reset both RAMs are zeroed with in_stall high.
// A new transaction is taken while the previous result waits; the second one
// holds in its result cycle until the output register is free.

module lattice_walk_distance_accumulator
    import lwda_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int MAX_WALKS = MAX_WALKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic                  direction,
    input  logic [1:0]            axis,
    input  logic [STEPNUM_W-1:0]  read_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [D2_W-1:0]       squared_distance,
    output logic [STEPNUM_W-1:0]  step_number,
    output logic                  walk_done,
    output logic                  block_done,
    output logic [BLK_W-1:0]      blocks_finished,
    output logic [DIST_W-1:0]     total_distance,
    output logic [SQTOT_W-1:0]    total_square,
    output logic                  saturated
);

    logic [WALKS_REG_W-1:0]       walks_per_block;
    logic [STEPS_REG_W-1:0]       steps_per_walk;
    lwda_cmd_t                    cmd;
    lwda_status_t                 status;
    logic [$clog2(MAX_STEPS)-1:0] addr;

    lwda_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .walks_per_block (walks_per_block),
        .steps_per_walk  (steps_per_walk)
    );

    lwda_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .addr     (addr)
    );

    lwda_dp #(
        .MAX_STEPS (MAX_STEPS),
        .MAX_WALKS (MAX_WALKS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .addr             (addr),
        .status           (status),
        .walks_per_block  (walks_per_block),
        .steps_per_walk   (steps_per_walk),
        .operation        (operation),
        .direction        (direction),
        .axis             (axis),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .squared_distance (squared_distance),
        .step_number      (step_number),
        .walk_done        (walk_done),
        .block_done       (block_done),
        .blocks_finished  (blocks_finished),
        .total_distance   (total_distance),
        .total_square     (total_square),
        .saturated        (saturated)
    );

endmodule

// ===== sv/lwda_ram.sv =====
`timescale 1ns / 1ps

module lwda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/lwda_regs.sv =====
`timescale 1ns / 1ps

module lwda_regs
    import lwda_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    output logic [WALKS_REG_W-1:0]  walks_per_block,
    output logic [STEPS_REG_W-1:0]  steps_per_walk
);

    logic [WALKS_REG_W-1:0] walks_reg;
    logic [STEPS_REG_W-1:0] steps_reg;
    reg_idx_t               idx;
    logic                   wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walks_reg <= WALKS_RESET;
            steps_reg <= STEPS_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_WALKS: walks_reg <= pwdata[WALKS_REG_W-1:0];
                REG_STEPS: steps_reg <= pwdata[STEPS_REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_WALKS: prdata = APB_DW'(walks_reg);
            REG_STEPS: prdata = APB_DW'(steps_reg);
            default:   prdata = '0;
        endcase
    end

    assign walks_per_block = walks_reg;
    assign steps_per_walk  = steps_reg;

endmodule

// ===== sv/lwda_ctrl.sv =====
`timescale 1ns / 1ps

module lwda_ctrl
    import lwda_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lwda_status_t                 status,
    output lwda_cmd_t                    cmd,
    output logic [$clog2(MAX_STEPS)-1:0] addr
);

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int CNT_W = $clog2(MAX_STEPS + 2);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == CNT_W'(MAX_STEPS - 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid && !stall_reg)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.out_free)
                begin
                    state_next = status.block_end ? S_SWEEP : S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_SWEEP:
            begin
                if (cnt_reg == CNT_W'(MAX_STEPS + 1))
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall     = stall_reg;
    assign cmd.accept   = in_valid & ~stall_reg;
    assign cmd.finish   = (state_reg == S_EXEC) & status.out_free;
    assign cmd.clear    = (state_reg == S_CLEAR);
    assign cmd.sweep_rd = (state_reg == S_SWEEP) && (cnt_reg < CNT_W'(MAX_STEPS));
    assign addr         = cnt_reg[IDX_W-1:0];

endmodule

// ===== sv/lwda_dp.sv =====
`timescale 1ns / 1ps

module lwda_dp
    import lwda_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int MAX_WALKS = MAX_WALKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lwda_cmd_t                    cmd,
    input  logic [$clog2(MAX_STEPS)-1:0] addr,
    output lwda_status_t                 status,
    input  logic [WALKS_REG_W-1:0]       walks_per_block,
    input  logic [STEPS_REG_W-1:0]       steps_per_walk,
    input  logic                         operation,
    input  logic                         direction,
    input  logic [1:0]                   axis,
    input  logic [STEPNUM_W-1:0]         read_index,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [D2_W-1:0]              squared_distance,
    output logic [STEPNUM_W-1:0]         step_number,
    output logic                         walk_done,
    output logic                         block_done,
    output logic [BLK_W-1:0]             blocks_finished,
    output logic [DIST_W-1:0]            total_distance,
    output logic [SQTOT_W-1:0]           total_square,
    output logic                         saturated
);

    localparam int IDX_W   = $clog2(MAX_STEPS);
    localparam int STEP_CW = $clog2(MAX_STEPS + 1);
    localparam int SW      = (STEP_CW > STEPS_REG_W) ? STEP_CW : STEPS_REG_W;
    localparam int WALK_W  = $clog2(MAX_WALKS + 1);
    localparam int WW      = (WALK_W > WALKS_REG_W) ? WALK_W : WALKS_REG_W;

    // walker state
    logic signed [POS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [IDX_W-1:0]        step_cnt_reg;
    logic [WALK_W-1:0]       walk_cnt_reg;
    logic [BLK_W-1:0]        blk_cnt_reg;

    // current transaction
    op_t                     op_reg;
    logic [D2_W-1:0]         d2_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    wdone_reg;
    logic                    bdone_reg;
    logic                    rd_ok_reg;

    // block-end sweep pipeline
    logic                    s1_valid_reg;
    logic [IDX_W-1:0]        s1_addr_reg;
    logic                    s2_valid_reg;
    logic [IDX_W-1:0]        s2_addr_reg;
    logic [SQ_PROD_W-1:0]    s2_sq_reg;
    logic [SUM_W-1:0]        s2_sum_reg;
    tot_t                    s2_tot_reg;

    logic                    out_valid_reg;
    logic [D2_W-1:0]         out_d2_reg;
    logic [STEPNUM_W-1:0]    out_step_reg;
    logic                    out_wdone_reg;
    logic                    out_bdone_reg;
    logic [BLK_W-1:0]        out_blk_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic [SQTOT_W-1:0]      out_sq_reg;
    logic                    out_sat_reg;

    // RAM ports
    logic                    sum_we, sum_re;
    logic [IDX_W-1:0]        sum_waddr, sum_raddr;
    logic [SUM_W-1:0]        sum_wdata, sum_rdata;
    logic                    tot_we, tot_re;
    logic [IDX_W-1:0]        tot_waddr, tot_raddr;
    tot_t                    tot_wdata, tot_rdata;

    logic                    is_step, is_read;
    logic signed [POS_W-1:0] delta, nx, ny, nz;
    logic signed [2*POS_W-1:0] sqx, sqy, sqz;
    logic [2*POS_W-1:0]      d2_wide;
    logic [SW-1:0]           steps_ext, steps_clamp, step_next;
    logic [WW-1:0]           walks_ext, walks_clamp, walk_next;
    logic                    wdone, bdone;
    logic                    rd_ok;
    logic                    out_free;
    logic [DIST_W:0]         dist_sum;
    logic [SQTOT_W:0]        sq_sum;
    tot_t                    tot_new;

    assign is_step = cmd.accept && (op_t'(operation) == OP_STEP);
    assign is_read = cmd.accept && (op_t'(operation) == OP_READ);

    assign delta = direction ? POS_W'(1) : -POS_W'(1);
    assign nx    = pos_x_reg + ((axis_t'(axis) == AXIS_X) ? delta : '0);
    assign ny    = pos_y_reg + ((axis_t'(axis) == AXIS_Y) ? delta : '0);
    assign nz    = pos_z_reg + ((axis_t'(axis) == AXIS_Z) ? delta : '0);
    assign sqx   = nx * nx;
    assign sqy   = ny * ny;
    assign sqz   = nz * nz;
    assign d2_wide = $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);

    assign steps_ext   = SW'(steps_per_walk);
    assign steps_clamp = (steps_ext == '0) ? SW'(1) :
                         (steps_ext > SW'(MAX_STEPS)) ? SW'(MAX_STEPS) : steps_ext;
    assign step_next   = SW'(step_cnt_reg) + SW'(1);
    assign wdone       = (step_next >= steps_clamp);

    assign walks_ext   = WW'(walks_per_block);
    assign walks_clamp = (walks_ext == '0) ? WW'(1) :
                         (walks_ext > WW'(MAX_WALKS)) ? WW'(MAX_WALKS) : walks_ext;
    assign walk_next   = WW'(walk_cnt_reg) + WW'(1);
    assign bdone       = wdone && (walk_next >= walks_clamp);

    assign rd_ok = (SW'(read_index) < SW'(MAX_STEPS));

    assign out_free         = ~out_valid_reg | ~out_stall;
    assign status.out_free  = out_free;
    assign status.block_end = bdone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            pos_z_reg    <= '0;
            step_cnt_reg <= '0;
            walk_cnt_reg <= '0;
            blk_cnt_reg  <= '0;
            bdone_reg    <= 1'b0;
        end
        else if (cmd.accept)
        begin
            bdone_reg <= is_step && bdone;
            if (is_step)
            begin
                if (wdone)
                begin
                    pos_x_reg    <= '0;
                    pos_y_reg    <= '0;
                    pos_z_reg    <= '0;
                    step_cnt_reg <= '0;
                    if (bdone)
                    begin
                        walk_cnt_reg <= '0;
                        if (blk_cnt_reg != BLK_MAX)
                        begin
                            blk_cnt_reg <= blk_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        walk_cnt_reg <= walk_next[WALK_W-1:0];
                    end
                end
                else
                begin
                    pos_x_reg    <= nx;
                    pos_y_reg    <= ny;
                    pos_z_reg    <= nz;
                    step_cnt_reg <= step_next[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op_t'(operation);
            d2_reg    <= d2_wide[D2_W-1:0];
            idx_reg   <= step_cnt_reg;
            wdone_reg <= wdone;
            rd_ok_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.sweep_rd;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= addr;
        s2_addr_reg <= s1_addr_reg;
        s2_sum_reg  <= sum_rdata;
        s2_sq_reg   <= sum_rdata * sum_rdata;
        s2_tot_reg  <= tot_rdata;
    end

    assign dist_sum = {1'b0, s2_tot_reg.dsum} + (DIST_W + 1)'(s2_sum_reg);
    assign sq_sum   = {1'b0, s2_tot_reg.sq} + (SQTOT_W + 1)'(s2_sq_reg);

    always_comb
    begin
        tot_new.dsum = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
        tot_new.sq   = sq_sum[SQTOT_W] ? '1 : sq_sum[SQTOT_W-1:0];
        tot_new.ovf  = s2_tot_reg.ovf | dist_sum[DIST_W] | sq_sum[SQTOT_W];
    end

    // per-step sums: step read-modify-write, zeroed by the sweep and after reset
    assign sum_re    = is_step | cmd.sweep_rd;
    assign sum_raddr = cmd.sweep_rd ? addr : step_cnt_reg;
    assign sum_we    = (cmd.finish && (op_reg == OP_STEP)) | s1_valid_reg | cmd.clear;
    assign sum_waddr = cmd.clear ? addr : (s1_valid_reg ? s1_addr_reg : idx_reg);
    assign sum_wdata = (cmd.finish && (op_reg == OP_STEP)) ?
                       sum_rdata + SUM_W'(d2_reg) : '0;

    assign tot_re    = is_read | cmd.sweep_rd;
    assign tot_raddr = cmd.sweep_rd ? addr : read_index[IDX_W-1:0];
    assign tot_we    = s2_valid_reg | cmd.clear;
    assign tot_waddr = cmd.clear ? addr : s2_addr_reg;
    assign tot_wdata = cmd.clear ? '0 : tot_new;

    lwda_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_STEPS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    lwda_ram #(
        .WIDTH (TOT_W),
        .DEPTH (MAX_STEPS)
    ) u_tot_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (tot_re),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_blk_reg <= blk_cnt_reg;
            if (op_reg == OP_STEP)
            begin
                out_d2_reg    <= d2_reg;
                out_step_reg  <= STEPNUM_W'(idx_reg);
                out_wdone_reg <= wdone_reg;
                out_bdone_reg <= bdone_reg;
                out_dist_reg  <= '0;
                out_sq_reg    <= '0;
                out_sat_reg   <= 1'b0;
            end
            else
            begin
                out_d2_reg    <= '0;
                out_step_reg  <= '0;
                out_wdone_reg <= 1'b0;
                out_bdone_reg <= 1'b0;
                out_dist_reg  <= rd_ok_reg ? tot_rdata.dsum : '0;
                out_sq_reg    <= rd_ok_reg ? tot_rdata.sq : '0;
                out_sat_reg   <= rd_ok_reg & tot_rdata.ovf;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign squared_distance = out_d2_reg;
    assign step_number      = out_step_reg;
    assign walk_done        = out_wdone_reg;
    assign block_done       = out_bdone_reg;
    assign blocks_finished  = out_blk_reg;
    assign total_distance   = out_dist_reg;
    assign total_square     = out_sq_reg;
    assign saturated        = out_sat_reg;

endmodule

// ===== tb/tb_lattice_walk_distance_accumulator.sv =====
`timescale 1ns / 1ps

module tb_lattice_walk_distance_accumulator;
    import lwda_pkg::*;

    localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 64'd1;
    localparam longint unsigned SQ_LIMIT   = (64'd1 << SQTOT_W) - 64'd1;
    localparam longint unsigned SUM_MASK   = (64'd1 << SUM_W) - 64'd1;

    typedef struct packed {
        logic [D2_W-1:0]      dist2;
        logic [STEPNUM_W-1:0] step;
        logic                 walk_end;
        logic                 block_end;
        logic [BLK_W-1:0]     blocks;
        logic [DIST_W-1:0]    tot_dist;
        logic [SQTOT_W-1:0]   tot_sq;
        logic                 sat;
    } walk_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 operation = 1'b0;
    logic                 direction = 1'b0;
    logic [1:0]           axis = '0;
    logic [STEPNUM_W-1:0] read_index = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [D2_W-1:0]      squared_distance;
    logic [STEPNUM_W-1:0] step_number;
    logic                 walk_done;
    logic                 block_done;
    logic [BLK_W-1:0]     blocks_finished;
    logic [DIST_W-1:0]    total_distance;
    logic [SQTOT_W-1:0]   total_square;
    logic                 saturated;

    bit calm = 1'b0;
    int mismatches = 0;
    walk_result_t pending_results[$];

    // walker state and register copies
    int unsigned walks_cfg = 100;
    int unsigned steps_cfg = 100;
    int px = 0, py = 0, pz = 0;
    int unsigned step_cnt = 0, walk_cnt = 0, blk_cnt = 0;
    longint unsigned blk_sum [MAX_STEPS_DEF] = '{default: 0};
    longint unsigned dist_tot [MAX_STEPS_DEF] = '{default: 0};
    longint unsigned sq_tot [MAX_STEPS_DEF] = '{default: 0};
    bit ovf [MAX_STEPS_DEF] = '{default: 0};

    lattice_walk_distance_accumulator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .direction        (direction),
        .axis             (axis),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .squared_distance (squared_distance),
        .step_number      (step_number),
        .walk_done        (walk_done),
        .block_done       (block_done),
        .blocks_finished  (blocks_finished),
        .total_distance   (total_distance),
        .total_square     (total_square),
        .saturated        (saturated)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99, 0) < 19);
    end

    function automatic walk_result_t advance_walk(op_t op, logic dir, logic [1:0] ax,
                                                  logic [STEPNUM_W-1:0] ridx);
        walk_result_t r;
        int delta, d2;
        int unsigned idx, steps, walks;
        longint unsigned s, sq;
        r = '0;
        if (op == OP_READ)
        begin
            r.tot_dist = DIST_W'(dist_tot[ridx]);
            r.tot_sq   = SQTOT_W'(sq_tot[ridx]);
            r.sat      = ovf[ridx];
            r.blocks   = BLK_W'(blk_cnt);
            return r;
        end
        steps = (steps_cfg == 0) ? 1 : steps_cfg;
        walks = (walks_cfg == 0) ? 1 : ((walks_cfg > MAX_WALKS_DEF) ? MAX_WALKS_DEF : walks_cfg);
        delta = dir ? 1 : -1;
        case (ax)
            AXIS_X:  px += delta;
            AXIS_Y:  py += delta;
            AXIS_Z:  pz += delta;
            default: ;
        endcase
        d2 = px * px + py * py + pz * pz;
        idx = step_cnt;
        blk_sum[idx] = (blk_sum[idx] + longint'(d2)) & SUM_MASK;
        step_cnt = idx + 1;
        if (step_cnt >= steps)
        begin
            r.walk_end = 1'b1;
            step_cnt = 0;
            px = 0;
            py = 0;
            pz = 0;
            walk_cnt++;
            if (walk_cnt >= walks)
            begin
                r.block_end = 1'b1;
                walk_cnt = 0;
                for (int j = 0; j < MAX_STEPS_DEF; j++)
                begin
                    s = blk_sum[j];
                    sq = s * s;
                    if (dist_tot[j] > DIST_LIMIT - s)
                    begin
                        dist_tot[j] = DIST_LIMIT;
                        ovf[j] = 1'b1;
                    end
                    else
                        dist_tot[j] += s;
                    if (sq_tot[j] > SQ_LIMIT - sq)
                    begin
                        sq_tot[j] = SQ_LIMIT;
                        ovf[j] = 1'b1;
                    end
                    else
                        sq_tot[j] += sq;
                    blk_sum[j] = 0;
                end
                if (blk_cnt < BLK_MAX)
                    blk_cnt++;
            end
        end
        r.dist2  = D2_W'(d2);
        r.step   = STEPNUM_W'(idx);
        r.blocks = BLK_W'(blk_cnt);
        return r;
    endfunction

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        walk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t result transaction expected none actual squared_distance %0d",
                         $time, squared_distance);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("squared_distance", want.dist2, squared_distance);
                compare_field("step_number", want.step, step_number);
                compare_field("walk_done", want.walk_end, walk_done);
                compare_field("block_done", want.block_end, block_done);
                compare_field("blocks_finished", want.blocks, blocks_finished);
                compare_field("total_distance", want.tot_dist, total_distance);
                compare_field("total_square", want.tot_sq, total_square);
                compare_field("saturated", want.sat, saturated);
            end
        end
    end

    task automatic send_item(op_t op, logic dir, logic [1:0] ax, logic [STEPNUM_W-1:0] ridx);
        if (!calm && $urandom_range(99, 0) < 19)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        direction  <= dir;
        axis       <= ax;
        read_index <= ridx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(advance_walk(op, dir, ax, ridx));
    endtask

    task automatic send_random_step();
        send_item(OP_STEP, 1'($urandom_range(1, 0)), 2'($urandom_range(3, 0)),
                  STEPNUM_W'($urandom_range(127, 0)));
    endtask

    task automatic send_read(int unsigned idx);
        send_item(OP_READ, 1'($urandom_range(1, 0)), 2'($urandom_range(3, 0)),
                  STEPNUM_W'(idx));
    endtask

    // idle until every result is back and any block sweep has run out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MAX_STEPS_DEF + 8) @(posedge clk);
    endtask

    task automatic apb_write(reg_idx_t r, logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (r == REG_WALKS)
            walks_cfg = v[WALKS_REG_W-1:0];
        else
            steps_cfg = v[STEPS_REG_W-1:0];
    endtask

    task automatic reconfigure(logic [APB_DW-1:0] walks_word, logic [APB_DW-1:0] steps_word);
        drain();
        apb_write(REG_WALKS, walks_word);
        apb_write(REG_STEPS, steps_word);
    endtask

    task automatic test_defaults();
        send_read(0);
        send_read(127);
        send_read(64);
        for (int a = 0; a < 4; a++)
        begin
            send_item(OP_STEP, 1'b1, 2'(a), 7'h7F);
            send_item(OP_STEP, 1'b0, 2'(a), 7'h00);
        end
        send_read(0);
    endtask

    task automatic test_register_extremes();
        // zero registers clamp to one; walk already past the new limit
        reconfigure(32'h0, 32'h0);
        repeat (4) send_random_step();
        send_read(0);
        reconfigure(32'hFFFF_F400, 32'hFFFF_FF81);
        repeat (12) send_random_step();
        reconfigure(32'h0000_07FF, 32'h1);
        repeat (6) send_random_step();
        // walk count already past the lowered block size
        reconfigure(32'd5, 32'd1);
        repeat (3) send_random_step();
        send_read(0);
    endtask

    task automatic test_longest_walk();
        reconfigure(32'd1, 32'd127);
        repeat (127) send_item(OP_STEP, 1'b1, AXIS_X, STEPNUM_W'($urandom_range(127, 0)));
        repeat (127) send_random_step();
        send_read(0);
        send_read(126);
        send_read(127);
        send_read(64);
    endtask

    task automatic test_random_walks();
        int sent, phase, len, w, st, span;
        sent = 0;
        phase = 0;
        while (sent < 1500)
        begin
            case ($urandom_range(9, 0))
                0:       w = 0;
                1:       w = $urandom_range(2047, 1025);
                2:       w = $urandom_range(40, 7);
                default: w = $urandom_range(6, 1);
            endcase
            case ($urandom_range(9, 0))
                0:       st = 0;
                1:       st = 127;
                2:       st = $urandom_range(126, 20);
                default: st = $urandom_range(12, 1);
            endcase
            reconfigure(($urandom & ~32'h7FF) | w, ($urandom & ~32'h7F) | st);
            calm = (phase == 3);
            span = (st == 0) ? 1 : st;
            len = $urandom_range(160, 60);
            repeat (len)
            begin
                if ($urandom_range(99, 0) < 85)
                    send_random_step();
                else if ($urandom_range(1, 0))
                    send_read($urandom_range(span - 1, 0));
                else
                    send_read($urandom_range(127, 0));
            end
            sent += len;
            phase++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_register_extremes();
        test_longest_walk();
        test_random_walks();
        drain();
        if (mismatches == 0)
            $display("PASS lattice_walk_distance_accumulator");
        else
            $display("FAIL lattice_walk_distance_accumulator");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("FAIL lattice_walk_distance_accumulator");
        $finish;
    end

endmodule
